// ===== sv/tcphtc_pkg.sv =====
package tcphtc_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IHL_NO_OPTIONS = 4'd5;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  OFS_OPTIONS    = 8'd54;
    localparam logic [7:0]  OFS_TCP        = 8'd34;
    localparam logic [8:0]  LEN_ETH        = 9'd14;
    localparam logic [8:0]  LEN_IP         = 9'd34;
    localparam logic [8:0]  LEN_TCP        = 9'd54;
    localparam logic [7:0]  OPT_END        = 8'd0;
    localparam logic [7:0]  OPT_NOP        = 8'd1;
    localparam logic [7:0]  OPT_MSS        = 8'd2;

    // flag bits kept from the tcp header
    localparam int FLAG_CWR = 2;
    localparam int FLAG_URG = 1;
    localparam int FLAG_RST = 0;

    localparam int FRAG_DF  = 14;

    typedef enum logic [2:0] {
        PH_KIND   = 3'd0,
        PH_LEN    = 3'd1,
        PH_SKIP   = 3'd2,
        PH_STOP   = 3'd3,
        PH_MSSLEN = 3'd4
    } t_opt_phase;

    typedef enum logic [2:0] {
        CFG_ACK_SPLIT     = 3'd0,
        CFG_MSS_LIMIT     = 3'd1,
        CFG_ACK_CWR_LIMIT = 3'd2,
        CFG_LENGTH_LIMIT  = 3'd3,
        CFG_TTL_UPPER     = 3'd4,
        CFG_TTL_LOWER     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] ack_split;
        logic [15:0] mss_limit;
        logic [31:0] ack_cwr_limit;
        logic [15:0] length_limit;
        logic [7:0]  ttl_upper;
        logic [7:0]  ttl_lower;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ack_split:     32'd284597952,
        mss_limit:     16'd1176,
        ack_cwr_limit: 32'd7806426,
        length_limit:  16'd41,
        ttl_upper:     8'd76,
        ttl_lower:     8'd63
    };

    typedef struct packed {
        logic [7:0]  byte_offset;
        logic [15:0] ether_type;
        logic [3:0]  ip_header_len;
        logic [7:0]  ip_protocol;
        logic [15:0] total_length;
        logic [15:0] frag_field;
        logic [7:0]  ttl_value;
        logic [31:0] ack_number;
        logic [2:0]  tcp_flag_bits;
        logic [3:0]  tcp_data_offset;
        t_opt_phase  option_phase;
        logic [7:0]  option_skip;
        logic [15:0] mss_value;
        logic [7:0]  mss_high;
        logic [1:0]  mss_pending;
    } t_frame;

    localparam t_frame FRAME_CLEAR = '{
        byte_offset:     8'd0,
        ether_type:      16'd0,
        ip_header_len:   4'd0,
        ip_protocol:     8'd0,
        total_length:    16'd0,
        frag_field:      16'd0,
        ttl_value:       8'd0,
        ack_number:      32'd0,
        tcp_flag_bits:   3'd0,
        tcp_data_offset: 4'd0,
        option_phase:    PH_KIND,
        option_skip:     8'd0,
        mss_value:       16'd0,
        mss_high:        8'd0,
        mss_pending:     2'd0
    };

endpackage

// ===== sv/tcphtc_if.sv =====
interface tcphtc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tcphtc_verdict_if;
    logic valid;
    logic ready;
    logic drop;

    modport source (output valid, output drop, input ready);
    modport sink   (input valid, input drop, output ready);
endinterface

interface tcphtc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tcp_header_tree_classifier_top.sv =====
// tcp header classifier: one pass/drop verdict per ethernet frame
//
// i_frame carries the frame one byte per beat from the destination address,
// with last set on the final byte. o_verdict carries one beat per frame with
// drop = 1 to drop, 0 to pass. i_cfg writes the six tree thresholds by index
// (0 ack split, 1 mss limit, 2 ack/cwr limit, 3 length limit, 4 ttl upper,
// 5 ttl lower); it is always ready and other indexes are ignored.
//
// every byte is parsed in the cycle it is accepted, so a byte can be taken
// every cycle unless a verdict is stalled. the verdict enters the output register
// in the cycle after the last byte is taken; the path is field capture plus 32-bit compares.
// if the receiver stalls, the verdict holds and i_frame.ready drops until it
// is taken; a waiting verdict taken in the same cycle does not stall input.
//
// reset clears the parser and the output valid and loads the default thresholds;
// the user must write configuration only while no frame is in progress; not enforced.
module tcp_header_tree_classifier_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tcphtc_frame_if.sink            i_frame,
    tcphtc_verdict_if.source        o_verdict,
    tcphtc_cfg_if.sink              i_cfg
);

    tcphtc_pkg::t_cfg   r_cfg;
    tcphtc_pkg::t_frame w_frame;
    logic [8:0]         w_len;
    logic               w_drop;
    logic               w_beat;
    logic               r_out_valid;
    logic               r_drop;

    assign i_frame.ready = !r_out_valid || o_verdict.ready;
    assign w_beat        = i_frame.valid && i_frame.ready;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tcphtc_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tcphtc_pkg::CFG_ACK_SPLIT:     r_cfg.ack_split     <= i_cfg.data;
                tcphtc_pkg::CFG_MSS_LIMIT:     r_cfg.mss_limit     <= i_cfg.data[15:0];
                tcphtc_pkg::CFG_ACK_CWR_LIMIT: r_cfg.ack_cwr_limit <= i_cfg.data;
                tcphtc_pkg::CFG_LENGTH_LIMIT:  r_cfg.length_limit  <= i_cfg.data[15:0];
                tcphtc_pkg::CFG_TTL_UPPER:     r_cfg.ttl_upper     <= i_cfg.data[7:0];
                tcphtc_pkg::CFG_TTL_LOWER:     r_cfg.ttl_lower     <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    tcphtc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_beat),
        .i_data_byte (i_frame.data_byte),
        .i_last      (i_frame.last),
        .o_frame     (w_frame),
        .o_len       (w_len)
    );

    tcphtc_tree u_tree (
        .i_frame (w_frame),
        .i_len   (w_len),
        .i_cfg   (r_cfg),
        .o_drop  (w_drop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_beat && i_frame.last) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_beat && i_frame.last) begin
            r_drop <= w_drop;
        end
    end

    assign o_verdict.valid = r_out_valid;
    assign o_verdict.drop  = r_drop;

    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && i_frame.last) |=> r_out_valid)
        else $error("no verdict after last beat");

    a_no_spurious_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(w_beat && i_frame.last)) |=> !r_out_valid)
        else $error("verdict without a last beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_verdict.ready) |-> !w_beat)
        else $error("beat accepted while a verdict is stalled");

endmodule

// ===== sv/tcphtc_parser.sv =====
module tcphtc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    output tcphtc_pkg::t_frame  o_frame,
    output logic [8:0]          o_len
);

    tcphtc_pkg::t_frame r_frame;
    tcphtc_pkg::t_frame n_frame;
    tcphtc_pkg::t_frame n_stored;

    logic [7:0] w_ofs;
    logic [7:0] w_kind_end;
    logic [7:0] w_skip_dec;

    assign w_ofs      = r_frame.byte_offset;
    assign w_kind_end = tcphtc_pkg::OFS_TCP + {2'b00, r_frame.tcp_data_offset, 2'b00};
    assign w_skip_dec = r_frame.option_skip - 8'd1;

    always_comb begin
        n_frame = r_frame;

        // fixed header fields, multi-byte ones in network order
        case (w_ofs) inside
            8'd12, 8'd13: n_frame.ether_type = {r_frame.ether_type[7:0], i_data_byte};
            8'd14: n_frame.ip_header_len = i_data_byte[3:0];
            8'd16, 8'd17: n_frame.total_length = {r_frame.total_length[7:0], i_data_byte};
            8'd20, 8'd21: n_frame.frag_field = {r_frame.frag_field[7:0], i_data_byte};
            8'd22: n_frame.ttl_value = i_data_byte;
            8'd23: n_frame.ip_protocol = i_data_byte;
            [8'd42:8'd45]: n_frame.ack_number = {r_frame.ack_number[23:0], i_data_byte};
            8'd46: n_frame.tcp_data_offset = i_data_byte[7:4];
            8'd47: n_frame.tcp_flag_bits = {i_data_byte[7], i_data_byte[5], i_data_byte[2]};
            default: ;
        endcase

        if (w_ofs >= tcphtc_pkg::OFS_OPTIONS) begin
            // mss bytes follow an mss length byte of two or more whatever that length says
            if (r_frame.mss_pending == 2'd2) begin
                n_frame.mss_high    = i_data_byte;
                n_frame.mss_pending = 2'd1;
            end else if (r_frame.mss_pending == 2'd1) begin
                n_frame.mss_value   = {r_frame.mss_high, i_data_byte};
                n_frame.mss_pending = 2'd0;
            end

            unique case (r_frame.option_phase)
                tcphtc_pkg::PH_KIND: begin
                    if (w_ofs >= w_kind_end || i_data_byte == tcphtc_pkg::OPT_END) begin
                        n_frame.option_phase = tcphtc_pkg::PH_STOP;
                    end else if (i_data_byte == tcphtc_pkg::OPT_MSS) begin
                        n_frame.option_phase = tcphtc_pkg::PH_MSSLEN;
                    end else if (i_data_byte != tcphtc_pkg::OPT_NOP) begin
                        n_frame.option_phase = tcphtc_pkg::PH_LEN;
                    end
                end
                tcphtc_pkg::PH_LEN, tcphtc_pkg::PH_MSSLEN: begin
                    if (i_data_byte < 8'd2) begin
                        n_frame.option_phase = tcphtc_pkg::PH_STOP;
                    end else begin
                        if (r_frame.option_phase == tcphtc_pkg::PH_MSSLEN) begin
                            n_frame.mss_pending = 2'd2;
                        end
                        n_frame.option_skip  = i_data_byte - 8'd2;
                        n_frame.option_phase = (i_data_byte == 8'd2) ?
                            tcphtc_pkg::PH_KIND : tcphtc_pkg::PH_SKIP;
                    end
                end
                tcphtc_pkg::PH_SKIP: begin
                    n_frame.option_skip = w_skip_dec;
                    if (w_skip_dec == 8'd0) begin
                        n_frame.option_phase = tcphtc_pkg::PH_KIND;
                    end
                end
                default: ;
            endcase
        end

        n_stored = n_frame;
        if (i_last) begin
            n_stored = tcphtc_pkg::FRAME_CLEAR;
        end else if (w_ofs != 8'hFF) begin
            n_stored.byte_offset = w_ofs + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= tcphtc_pkg::FRAME_CLEAR;
        end else if (i_beat) begin
            r_frame <= n_stored;
        end
    end

    assign o_frame = n_frame;
    assign o_len   = {1'b0, w_ofs} + 9'd1;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_frame.byte_offset == 8'd0 &&
                                r_frame.option_phase == tcphtc_pkg::PH_KIND))
        else $error("frame state not cleared after last beat");

    a_offset_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && !i_last) |=> (r_frame.byte_offset >= $past(r_frame.byte_offset)))
        else $error("byte offset went backwards within a frame");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && !i_last && r_frame.option_phase == tcphtc_pkg::PH_STOP)
        |=> (r_frame.option_phase == tcphtc_pkg::PH_STOP))
        else $error("option walk left the stopped phase");

endmodule

// ===== sv/tcphtc_tree.sv =====
module tcphtc_tree (
    input  tcphtc_pkg::t_frame i_frame,
    input  logic [8:0]         i_len,
    input  tcphtc_pkg::t_cfg   i_cfg,
    output logic               o_drop
);

    logic w_screened;

    // short, non-ipv4, optioned, fragmented or non-tcp frames pass
    assign w_screened = (i_len >= tcphtc_pkg::LEN_ETH) &&
                        (i_frame.ether_type == tcphtc_pkg::ETHERTYPE_IPV4) &&
                        (i_len >= tcphtc_pkg::LEN_IP) &&
                        (i_frame.ip_header_len == tcphtc_pkg::IHL_NO_OPTIONS) &&
                        (i_frame.frag_field[13:0] == 14'd0) &&
                        (i_frame.ip_protocol == tcphtc_pkg::PROTO_TCP) &&
                        (i_len >= tcphtc_pkg::LEN_TCP);

    always_comb begin
        o_drop = 1'b0;
        if (w_screened) begin
            if (i_frame.ack_number < i_cfg.ack_split) begin
                if (i_frame.tcp_flag_bits[tcphtc_pkg::FLAG_URG]) begin
                    o_drop = 1'b1;
                end else if (!i_frame.tcp_flag_bits[tcphtc_pkg::FLAG_CWR]) begin
                    o_drop = !(i_frame.mss_value < i_cfg.mss_limit);
                end else begin
                    o_drop = !(i_frame.ack_number < i_cfg.ack_cwr_limit);
                end
            end else if (!i_frame.frag_field[tcphtc_pkg::FRAG_DF]) begin
                if (i_frame.total_length < i_cfg.length_limit) begin
                    o_drop = !i_frame.tcp_flag_bits[tcphtc_pkg::FLAG_RST];
                end
            end else if (i_frame.ttl_value < i_cfg.ttl_upper) begin
                o_drop = !(i_frame.ttl_value < i_cfg.ttl_lower);
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
class verdict_scoreboard;
    tcphtc_pkg::t_cfg   limits;
    tcphtc_pkg::t_frame hdr;
    logic               expected_drop[$];
    int                 errors;
    int                 checked;
    int                 drops;

    function new();
        limits  = tcphtc_pkg::CFG_RESET;
        hdr     = tcphtc_pkg::FRAME_CLEAR;
        errors  = 0;
        checked = 0;
        drops   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (tcphtc_pkg::t_cfg_index'(idx))
            tcphtc_pkg::CFG_ACK_SPLIT:     limits.ack_split     = value;
            tcphtc_pkg::CFG_MSS_LIMIT:     limits.mss_limit     = value[15:0];
            tcphtc_pkg::CFG_ACK_CWR_LIMIT: limits.ack_cwr_limit = value;
            tcphtc_pkg::CFG_LENGTH_LIMIT:  limits.length_limit  = value[15:0];
            tcphtc_pkg::CFG_TTL_UPPER:     limits.ttl_upper     = value[7:0];
            tcphtc_pkg::CFG_TTL_LOWER:     limits.ttl_lower     = value[7:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_drop.size();
    endfunction

    function logic tree_verdict(logic [8:0] len);
        if (len < tcphtc_pkg::LEN_ETH || hdr.ether_type != tcphtc_pkg::ETHERTYPE_IPV4)
            return 1'b0;
        if (len < tcphtc_pkg::LEN_IP || hdr.ip_header_len != tcphtc_pkg::IHL_NO_OPTIONS)
            return 1'b0;
        if (hdr.frag_field[13:0] != 14'd0) return 1'b0;
        if (hdr.ip_protocol != tcphtc_pkg::PROTO_TCP || len < tcphtc_pkg::LEN_TCP)
            return 1'b0;
        if (hdr.ack_number < limits.ack_split) begin
            if (hdr.tcp_flag_bits[tcphtc_pkg::FLAG_URG]) return 1'b1;
            if (!hdr.tcp_flag_bits[tcphtc_pkg::FLAG_CWR])
                return hdr.mss_value >= limits.mss_limit;
            return hdr.ack_number >= limits.ack_cwr_limit;
        end
        if (!hdr.frag_field[tcphtc_pkg::FRAG_DF]) begin
            if (hdr.total_length < limits.length_limit)
                return !hdr.tcp_flag_bits[tcphtc_pkg::FLAG_RST];
            return 1'b0;
        end
        if (hdr.ttl_value < limits.ttl_upper) return hdr.ttl_value >= limits.ttl_lower;
        return 1'b0;
    endfunction

    function void walk_options(logic [7:0] o, logic [7:0] b);
        // mss bytes are taken regardless of what the walk does with them
        if (hdr.mss_pending == 2'd2) begin
            hdr.mss_high    = b;
            hdr.mss_pending = 2'd1;
        end else if (hdr.mss_pending == 2'd1) begin
            hdr.mss_value   = {hdr.mss_high, b};
            hdr.mss_pending = 2'd0;
        end
        case (hdr.option_phase)
            tcphtc_pkg::PH_KIND: begin
                if (int'(o) >= int'(tcphtc_pkg::OFS_TCP) + 4 * int'(hdr.tcp_data_offset)
                    || b == tcphtc_pkg::OPT_END)
                    hdr.option_phase = tcphtc_pkg::PH_STOP;
                else if (b == tcphtc_pkg::OPT_MSS)
                    hdr.option_phase = tcphtc_pkg::PH_MSSLEN;
                else if (b != tcphtc_pkg::OPT_NOP)
                    hdr.option_phase = tcphtc_pkg::PH_LEN;
            end
            tcphtc_pkg::PH_LEN, tcphtc_pkg::PH_MSSLEN: begin
                if (b < 8'd2) begin
                    hdr.option_phase = tcphtc_pkg::PH_STOP;
                end else begin
                    if (hdr.option_phase == tcphtc_pkg::PH_MSSLEN) hdr.mss_pending = 2'd2;
                    hdr.option_skip = b - 8'd2;
                    if (hdr.option_skip != 8'd0) hdr.option_phase = tcphtc_pkg::PH_SKIP;
                    else hdr.option_phase = tcphtc_pkg::PH_KIND;
                end
            end
            tcphtc_pkg::PH_SKIP: begin
                hdr.option_skip = hdr.option_skip - 8'd1;
                if (hdr.option_skip == 8'd0) hdr.option_phase = tcphtc_pkg::PH_KIND;
            end
            default: ;
        endcase
    endfunction

    function void note_byte(logic [7:0] b, logic l);
        logic [7:0] o;
        o = hdr.byte_offset;
        case (o)
            8'd12, 8'd13: hdr.ether_type   = {hdr.ether_type[7:0], b};
            8'd14:        hdr.ip_header_len = b[3:0];
            8'd16, 8'd17: hdr.total_length = {hdr.total_length[7:0], b};
            8'd20, 8'd21: hdr.frag_field   = {hdr.frag_field[7:0], b};
            8'd22:        hdr.ttl_value    = b;
            8'd23:        hdr.ip_protocol  = b;
            8'd42, 8'd43, 8'd44, 8'd45: hdr.ack_number = {hdr.ack_number[23:0], b};
            8'd46:        hdr.tcp_data_offset = b[7:4];
            8'd47:        hdr.tcp_flag_bits   = {b[7], b[5], b[2]};
            default: ;
        endcase
        if (o >= tcphtc_pkg::OFS_OPTIONS) walk_options(o, b);
        if (l) begin
            expected_drop.push_back(tree_verdict({1'b0, o} + 9'd1));
            hdr = tcphtc_pkg::FRAME_CLEAR;
        end else if (hdr.byte_offset != 8'hFF) begin
            hdr.byte_offset = hdr.byte_offset + 8'd1;
        end
    endfunction

    function void check_verdict(logic drop);
        logic want;
        if (expected_drop.size() == 0) begin
            $error("drop: no verdict expected, actual %0d", drop);
            errors++;
            return;
        end
        want = expected_drop.pop_front();
        checked++;
        if (drop) drops++;
        if (drop !== want) begin
            $error("drop: expected %0d, actual %0d", want, drop);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] TCP_CWR = 8'h80;
    localparam logic [7:0] TCP_URG = 8'h20;
    localparam logic [7:0] TCP_RST = 8'h04;

    logic i_clk;
    logic i_rst_n;

    tcphtc_frame_if   frame_ch ();
    tcphtc_verdict_if verdict_ch ();
    tcphtc_cfg_if     cfg_ch ();

    tcp_header_tree_classifier_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (frame_ch),
        .o_verdict (verdict_ch),
        .i_cfg     (cfg_ch)
    );

    verdict_scoreboard sb = new();

    logic [7:0]       frame_bytes[$];
    tcphtc_pkg::t_cfg cur_cfg = tcphtc_pkg::CFG_RESET;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               bytes_sent = 0;
    int               frames_sent = 0;
    int               cfg_writes = 0;
    int               stalled_cycles = 0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one place sees every beat: verdicts are checked before new expectations land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (verdict_ch.valid && verdict_ch.ready) sb.check_verdict(verdict_ch.drop);
            if (frame_ch.valid && frame_ch.ready)
                sb.note_byte(frame_ch.data_byte, frame_ch.last);
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
                cfg_writes++;
            end
            if ((verdict_ch.valid && verdict_ch.ready) || (frame_ch.valid && frame_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] near(logic [31:0] v);
        logic [31:0] d;
        d = $urandom_range(0, 4);
        return v + d - 32'd2;
    endfunction

    function automatic logic [31:0] pick_value(int bits);
        logic [31:0] full;
        full = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return full;
            default: return $urandom() & full;
        endcase
    endfunction

    function automatic tcphtc_pkg::t_cfg pick_thresholds();
        tcphtc_pkg::t_cfg c;
        c.ack_split     = pick_value(32);
        c.mss_limit     = 16'(pick_value(16));
        c.ack_cwr_limit = pick_value(32);
        c.length_limit  = 16'(pick_value(16));
        c.ttl_upper     = 8'(pick_value(8));
        c.ttl_lower     = 8'(pick_value(8));
        return c;
    endfunction

    task automatic set_threshold(input tcphtc_pkg::t_cfg_index idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic load_thresholds(input tcphtc_pkg::t_cfg c);
        set_threshold(tcphtc_pkg::CFG_ACK_SPLIT, c.ack_split);
        set_threshold(tcphtc_pkg::CFG_MSS_LIMIT, {16'd0, c.mss_limit});
        set_threshold(tcphtc_pkg::CFG_ACK_CWR_LIMIT, c.ack_cwr_limit);
        set_threshold(tcphtc_pkg::CFG_LENGTH_LIMIT, {16'd0, c.length_limit});
        set_threshold(tcphtc_pkg::CFG_TTL_UPPER, {24'd0, c.ttl_upper});
        set_threshold(tcphtc_pkg::CFG_TTL_LOWER, {24'd0, c.ttl_lower});
        // unused indexes must leave the thresholds alone
        if ($urandom_range(0, 2) == 0) begin
            for (int k = 6; k < 8; k++) set_threshold(tcphtc_pkg::t_cfg_index'(k), $urandom());
        end
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic wait_drain();
        frame_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_ch.valid     <= 1'b1;
        frame_ch.data_byte <= b;
        frame_ch.last      <= l;
        do @(posedge i_clk); while (!frame_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input int cut);
        int n;
        n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
        for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
        frames_sent++;
    endtask

    task automatic push_rand(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_opts(input int n, input logic [63:0] v);
        for (int i = 0; i < n; i++) frame_bytes.push_back(v[8 * (n - 1 - i) +: 8]);
    endtask

    task automatic tcp_header(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [15:0] tot_len, input logic [15:0] frag,
                              input logic [7:0] ttl, input logic [7:0] proto,
                              input logic [31:0] ack, input logic [3:0] doff,
                              input logic [7:0] flags);
        frame_bytes.delete();
        push_rand(12);
        push_opts(2, 64'(etype));
        push_opts(1, 64'({4'h4, ihl}));
        push_rand(1);
        push_opts(2, 64'(tot_len));
        push_rand(2);
        push_opts(2, 64'(frag));
        push_opts(2, 64'({ttl, proto}));
        push_rand(18);
        push_opts(4, 64'(ack));
        push_opts(1, 64'({doff, 4'($urandom_range(0, 15))}));
        push_opts(1, 64'(flags));
        push_rand(6);
    endtask

    task automatic add_options(input int count);
        int start;
        int len;
        start = frame_bytes.size();
        while (frame_bytes.size() - start < count) begin
            case ($urandom_range(0, 9))
                0, 1: frame_bytes.push_back(tcphtc_pkg::OPT_NOP);
                2:    frame_bytes.push_back(tcphtc_pkg::OPT_END);
                3, 4: begin
                    push_opts(2, 64'({tcphtc_pkg::OPT_MSS, 8'd4}));
                    if ($urandom_range(0, 1) == 0)
                        push_opts(2, 64'(near(32'(cur_cfg.mss_limit))));
                    else push_rand(2);
                end
                5: begin
                    push_opts(2, 64'({tcphtc_pkg::OPT_MSS, 8'($urandom_range(0, 6))}));
                    push_rand(2);
                end
                6, 7: begin
                    len = $urandom_range(2, 8);
                    push_opts(2, 64'({8'($urandom_range(3, 255)), 8'(len)}));
                    push_rand(len - 2);
                end
                8: push_opts(2, 64'({8'($urandom_range(3, 255)), 8'($urandom_range(0, 1))}));
                default: push_rand(1);
            endcase
        end
    endtask

    task automatic random_tcp();
        logic [15:0] etype, tot_len, frag;
        logic [3:0]  ihl, doff;
        logic [7:0]  ttl, proto;
        logic [31:0] ack;
        etype = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : tcphtc_pkg::ETHERTYPE_IPV4;
        ihl   = ($urandom_range(0, 19) == 0) ? 4'($urandom()) : tcphtc_pkg::IHL_NO_OPTIONS;
        proto = ($urandom_range(0, 19) == 0) ? 8'($urandom()) : tcphtc_pkg::PROTO_TCP;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: frag = 16'h0000;
            4, 5, 6, 7: frag = 16'h4000;
            8:          frag = 16'($urandom_range(0, 1) << tcphtc_pkg::FRAG_DF)
                               | 16'd1 << $urandom_range(0, 13);
            default:    frag = 16'($urandom());
        endcase
        case ($urandom_range(0, 2))
            0:       ttl = 8'(near(32'(cur_cfg.ttl_upper)));
            1:       ttl = 8'(near(32'(cur_cfg.ttl_lower)));
            default: ttl = 8'($urandom());
        endcase
        case ($urandom_range(0, 2))
            0:       tot_len = 16'(near(32'(cur_cfg.length_limit)));
            1:       tot_len = 16'($urandom());
            default: tot_len = 16'($urandom_range(40, 120));
        endcase
        case ($urandom_range(0, 4))
            0:       ack = $urandom();
            1:       ack = near(cur_cfg.ack_split);
            2:       ack = near(cur_cfg.ack_cwr_limit);
            3:       ack = $urandom_range(0, 255);
            default: ack = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        doff = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(5, 8)) : 4'($urandom());
        tcp_header(etype, ihl, tot_len, frag, ttl, proto, ack, doff, 8'($urandom()));
        add_options((doff > 4'd5) ? (int'(doff) - 5) * 4 : $urandom_range(0, 4));
        push_rand($urandom_range(0, 12));
    endtask

    task automatic random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            random_tcp();
            send_frame((r >= 72) ? $urandom_range(1, frame_bytes.size()) : 0);
        end else begin
            frame_bytes.delete();
            push_rand(($urandom_range(0, 7) == 0) ? $urandom_range(256, 300)
                                                  : $urandom_range(1, 60));
            send_frame(0);
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int start;
        int n;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start = bytes_sent;
        n = 0;
        while (bytes_sent - start < 217 || n < 14) begin
            if (n % 8 == 0) begin
                wait_drain();
                load_thresholds(pick_thresholds());
            end else if ($urandom_range(0, 14) == 0) begin
                wait_drain();
            end
            random_frame();
            n++;
        end
    endtask

    task automatic directed_frames();
        tcphtc_pkg::t_cfg d;
        d = tcphtc_pkg::CFG_RESET;
        // short frames and header cases that must pass
        frame_bytes.delete();
        push_rand(1);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, TCP_URG);
        send_frame(13);
        send_frame(33);
        send_frame(53);
        tcp_header(16'h86DD, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0, 8'd64,
                   tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, TCP_URG);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, 4'd6, 16'd60, 16'h0, 8'd64,
                   tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, TCP_URG);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h4001,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, TCP_URG);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h2000,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, TCP_URG);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, 8'd17, 32'd0, 4'd5, TCP_URG);
        send_frame(0);
        // left branch
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, d.ack_split - 32'd1, 4'd5, TCP_URG);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd6, 8'h00);
        push_opts(4, 64'({tcphtc_pkg::OPT_MSS, 8'd4, d.mss_limit - 16'd1}));
        send_frame(0);
        // nop, a skipped option, then mss at the limit
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd7, 8'h00);
        push_opts(8, {tcphtc_pkg::OPT_NOP, 8'd3, 8'd3, 8'hAA, tcphtc_pkg::OPT_MSS, 8'd4,
                      d.mss_limit});
        send_frame(0);
        // mss cut off by the end of the frame
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd6, 8'h00);
        push_opts(3, 64'({tcphtc_pkg::OPT_MSS, 8'd4, 8'hFF}));
        send_frame(0);
        // end of list before mss
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd7, 8'h00);
        push_opts(8, {tcphtc_pkg::OPT_END, tcphtc_pkg::OPT_MSS, 8'd4, 16'hFFFF, 24'd0});
        send_frame(0);
        // length below two stops the walk
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd7, 8'h00);
        push_opts(8, {8'd5, 8'd1, tcphtc_pkg::OPT_MSS, 8'd4, 16'hFFFF, 16'd0});
        send_frame(0);
        // no option space: mss in the payload is ignored
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd5, 8'h00);
        push_opts(4, 64'({tcphtc_pkg::OPT_MSS, 8'd4, 16'hFFFF}));
        send_frame(0);
        // mss with a length of two still takes the next two bytes
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd6, 8'h00);
        push_opts(4, 64'({tcphtc_pkg::OPT_MSS, 8'd2, 16'hFFFF}));
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, d.ack_cwr_limit - 32'd1, 4'd5, TCP_CWR);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, d.ack_cwr_limit, 4'd5, TCP_CWR);
        send_frame(0);
        // right branch, df clear
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS,
                   d.length_limit - 16'd1, 16'h0, 8'd64, tcphtc_pkg::PROTO_TCP,
                   d.ack_split, 4'd5, TCP_RST);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS,
                   d.length_limit - 16'd1, 16'h0, 8'd64, tcphtc_pkg::PROTO_TCP,
                   d.ack_split, 4'd5, 8'h00);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS,
                   d.length_limit, 16'h0, 8'd64, tcphtc_pkg::PROTO_TCP,
                   d.ack_split, 4'd5, 8'h00);
        send_frame(0);
        // right branch, df set
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h4000,
                   d.ttl_upper, tcphtc_pkg::PROTO_TCP, 32'hFFFF_FFFF, 4'd5, 8'h00);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h4000,
                   d.ttl_upper - 8'd1, tcphtc_pkg::PROTO_TCP, 32'hFFFF_FFFF, 4'd5, 8'h00);
        send_frame(0);
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd60, 16'h4000,
                   d.ttl_lower - 8'd1, tcphtc_pkg::PROTO_TCP, 32'hFFFF_FFFF, 4'd5, 8'h00);
        send_frame(0);
        // long frame runs the offset into saturation
        tcp_header(tcphtc_pkg::ETHERTYPE_IPV4, tcphtc_pkg::IHL_NO_OPTIONS, 16'd300, 16'h0,
                   8'd64, tcphtc_pkg::PROTO_TCP, 32'd0, 4'd6, 8'h00);
        push_opts(4, 64'({tcphtc_pkg::OPT_MSS, 8'd4, 16'hFFFF}));
        push_rand(250);
        send_frame(0);
        frame_bytes.delete();
        push_opts(8, 64'd0);
        for (int i = 0; i < 7; i++) push_opts(8, 64'd0);
        send_frame(0);
        frame_bytes.delete();
        for (int i = 0; i < 8; i++) push_opts(8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(0);
    endtask

    initial begin
        tcphtc_pkg::t_cfg c;
        frame_ch.valid     <= 1'b0;
        frame_ch.data_byte <= 8'd0;
        frame_ch.last      <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= tcphtc_pkg::CFG_ACK_SPLIT;
        cfg_ch.data        <= 32'd0;
        i_rst_n            <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 75;
        directed_frames();

        // threshold extremes
        wait_drain();
        c = '{default: '0};
        load_thresholds(c);
        repeat (3) random_frame();
        wait_drain();
        c = '{default: '1};
        load_thresholds(c);
        repeat (3) random_frame();

        random_phase(7, 75);
        random_phase(75, 7);
        random_phase(0, 0);

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("drop: %0d verdicts never arrived", sb.pending());
            sb.errors++;
        end
        $display("covered %0d frames, %0d bytes and %0d threshold writes",
                 frames_sent, bytes_sent, cfg_writes);
        $display("checked %0d verdicts, %0d of them drops, %0d errors",
                 sb.checked, sb.drops, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
